FILE: sv/tach_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tach_pkg;

    // Field widths fixed by the item and result formats.
    localparam int TIME_W     = 16;
    localparam int PERIOD_W   = TIME_W + 1;
    localparam int NUM_W      = 32;
    localparam int MULT_W     = 16;
    localparam int RPM_W      = 16;
    localparam int DWELL_W    = 8;
    localparam int DIV_CNT_W  = $clog2(NUM_W);

    // Stream widths.
    localparam int S_DATA_W   = 2 * TIME_W;
    localparam int S_USER_W   = 2;
    localparam int M_DATA_W   = RPM_W + DWELL_W;

    // Configuration port.
    localparam int CFG_DATA_W = 32;
    localparam int PADDR_W    = 4;
    localparam int REG_IDX_W  = 2;

    localparam logic [REG_IDX_W-1:0] REG_RPM_DIVIDEND     = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_DWELL_MULTIPLIER = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_DWELL_OFFSET     = 2'd2;

    // Item kinds carried in the lowest tuser bit.
    localparam logic KIND_CAPTURE = 1'b0;
    localparam logic KIND_CLEAR   = 1'b1;

    // Queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;

    // Defaults of the averaging window.
    localparam int DEF_AVG_DEPTH = 8;
    localparam int DEF_AVG_SHIFT = 3;

    typedef struct packed {
        logic [NUM_W-1:0]  rpm_dividend;
        logic [MULT_W-1:0] dwell_multiplier;
        logic [TIME_W-1:0] dwell_offset;
    } cfg_t;

    // One classified item, ready for the dividers.
    typedef struct packed {
        logic                kind;
        logic                overflowed;
        logic [PERIOD_W-1:0] period;
        logic [NUM_W-1:0]    rpm_num;
        logic [NUM_W-1:0]    dwell_num;
    } q_entry_t;

endpackage

`default_nettype wire

FILE: sv/tach_front.sv
`timescale 1ns / 1ps
`default_nettype none

module tach_front (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [tach_pkg::S_DATA_W-1:0] s_tdata,
    input  wire logic [tach_pkg::S_USER_W-1:0] s_tuser,
    input  wire tach_pkg::cfg_t            cfg,
    output tach_pkg::q_entry_t             push_data,
    output logic                           push_valid,
    input  wire logic                      push_ready
);
    import tach_pkg::*;

    q_entry_t            entry_reg, entry_next;
    logic                valid_reg, valid_next;
    logic [TIME_W-1:0]   high_time;
    logic [TIME_W-1:0]   low_time;
    logic [PERIOD_W-1:0] high_offset;
    logic [PERIOD_W+MULT_W-1:0] dwell_prod;
    logic                accept;

    // The stage frees up when its beat moves into the queue.
    assign s_tready = !valid_reg || push_ready;
    assign accept   = s_tvalid && s_tready;

    assign high_time = s_tdata[TIME_W-1:0];
    assign low_time  = s_tdata[2*TIME_W-1:TIME_W];

    // Period and the dwell numerator; the product wraps to 32 bits.
    assign high_offset = {1'b0, high_time} + {1'b0, cfg.dwell_offset};
    assign dwell_prod  = high_offset * cfg.dwell_multiplier;

    always_comb begin
        entry_next = entry_reg;
        valid_next = valid_reg;
        if (push_valid && push_ready) begin
            valid_next = 1'b0;
        end
        if (accept) begin
            entry_next.kind       = s_tuser[0];
            entry_next.overflowed = s_tuser[1];
            entry_next.period     = {1'b0, high_time} + {1'b0, low_time};
            entry_next.rpm_num    = cfg.rpm_dividend;
            entry_next.dwell_num  = dwell_prod[NUM_W-1:0];
            valid_next            = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign push_valid = valid_reg;
    assign push_data  = entry_reg;

endmodule

`default_nettype wire

FILE: sv/tach_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module tach_fifo (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire tach_pkg::q_entry_t push_data,
    input  wire logic           push_valid,
    output logic                push_ready,
    output tach_pkg::q_entry_t  pop_data,
    output logic                pop_valid,
    input  wire logic           pop_ready
);
    import tach_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    q_entry_t         slots_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slots_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

FILE: sv/tach_div.sv
`timescale 1ns / 1ps
`default_nettype none

module tach_div (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [tach_pkg::NUM_W-1:0]    numer,
    input  wire logic [tach_pkg::PERIOD_W-1:0] denom,
    output logic                               done,
    output logic [tach_pkg::NUM_W-1:0]         quot
);
    import tach_pkg::*;

    logic [NUM_W-1:0]     num_reg, num_next;
    logic [PERIOD_W-1:0]  den_reg, den_next;
    logic [PERIOD_W-1:0]  rem_reg, rem_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [PERIOD_W:0]    rem_shift;
    logic [PERIOD_W:0]    diff;

    // One restoring step per cycle. For a nonzero divisor the remainder stays
    // below it, and a zero divisor makes every quotient bit one.
    assign rem_shift = {rem_reg, num_reg[NUM_W-1]};
    assign diff      = rem_shift - {1'b0, den_reg};

    always_comb begin
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            num_next  = numer;
            den_next  = denom;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!diff[PERIOD_W] || (den_reg == '0)) begin
                rem_next = diff[PERIOD_W-1:0];
                num_next = {num_reg[NUM_W-2:0], 1'b1};
            end else begin
                rem_next = rem_shift[PERIOD_W-1:0];
                num_next = {num_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(NUM_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign quot = num_reg;

endmodule

`default_nettype wire

FILE: sv/tach_back.sv
`timescale 1ns / 1ps
`default_nettype none

module tach_back #(
    parameter int AVG_DEPTH = tach_pkg::DEF_AVG_DEPTH,
    parameter int AVG_SHIFT = tach_pkg::DEF_AVG_SHIFT
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire tach_pkg::q_entry_t            pop_data,
    input  wire logic                          pop_valid,
    output logic                               pop_ready,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [tach_pkg::M_DATA_W-1:0]      m_tdata
);
    import tach_pkg::*;

    localparam int IDX_W   = $clog2(AVG_DEPTH);
    localparam int SUM_R_W = RPM_W + IDX_W;
    localparam int SUM_D_W = DWELL_W + IDX_W;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_RES  = 3'b100
    } back_state_t;

    back_state_t          state_reg, state_next;
    logic                 ovf_reg, ovf_next;
    logic [IDX_W-1:0]     widx_reg, widx_next;
    logic [AVG_DEPTH-1:0] valid_reg, valid_next;
    logic [SUM_R_W-1:0]   sum_rpm_reg, sum_rpm_next;
    logic [SUM_D_W-1:0]   sum_dw_reg, sum_dw_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0]  m_tdata_reg, m_tdata_next;

    // History rings, read every cycle at the write position.
    logic [RPM_W-1:0]     rpm_mem [AVG_DEPTH];
    logic [DWELL_W-1:0]   dwell_mem [AVG_DEPTH];
    logic [RPM_W-1:0]     rd_rpm_reg;
    logic [DWELL_W-1:0]   rd_dw_reg;
    logic                 mem_we;

    logic                 div_start;
    logic                 rpm_done;
    logic                 dw_done;
    logic [NUM_W-1:0]     rpm_quot;
    logic [NUM_W-1:0]     dw_quot;
    logic [RPM_W-1:0]     rpm_sample;
    logic [DWELL_W-1:0]   dw_sample;
    logic [RPM_W-1:0]     old_rpm;
    logic [DWELL_W-1:0]   old_dw;
    logic [SUM_R_W-1:0]   rpm_shifted;
    logic [SUM_D_W-1:0]   dw_shifted;
    logic                 out_free;

    tach_div u_rpm_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .numer   (pop_data.rpm_num),
        .denom   (pop_data.period),
        .done    (rpm_done),
        .quot    (rpm_quot)
    );

    tach_div u_dwell_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .numer   (pop_data.dwell_num),
        .denom   (pop_data.period),
        .done    (dw_done),
        .quot    (dw_quot)
    );

    assign rpm_sample = rpm_quot[RPM_W-1:0];
    assign dw_sample  = dw_quot[DWELL_W-1:0];

    // A slot not written since the last clear reads as zero.
    assign old_rpm = valid_reg[widx_reg] ? rd_rpm_reg : '0;
    assign old_dw  = valid_reg[widx_reg] ? rd_dw_reg : '0;

    assign rpm_shifted = sum_rpm_reg >> AVG_SHIFT;
    assign dw_shifted  = sum_dw_reg >> AVG_SHIFT;
    assign out_free    = !m_tvalid_reg || m_tready;

    // Sequencer: take an item, divide or clear, update sums, report.
    always_comb begin
        state_next    = state_reg;
        ovf_next      = ovf_reg;
        widx_next     = widx_reg;
        valid_next    = valid_reg;
        sum_rpm_next  = sum_rpm_reg;
        sum_dw_next   = sum_dw_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        pop_ready     = 1'b0;
        div_start     = 1'b0;
        mem_we        = 1'b0;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (pop_valid) begin
                    pop_ready = 1'b1;
                    ovf_next  = pop_data.overflowed;
                    if (pop_data.kind == KIND_CLEAR) begin
                        valid_next   = '0;
                        sum_rpm_next = '0;
                        sum_dw_next  = '0;
                        state_next   = ST_RES;
                    end else begin
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (rpm_done && dw_done) begin
                    mem_we               = 1'b1;
                    valid_next[widx_reg] = 1'b1;
                    sum_rpm_next = sum_rpm_reg - SUM_R_W'(old_rpm) + SUM_R_W'(rpm_sample);
                    sum_dw_next  = sum_dw_reg - SUM_D_W'(old_dw) + SUM_D_W'(dw_sample);
                    widx_next    = (widx_reg == IDX_W'(AVG_DEPTH - 1)) ? '0
                                                                       : widx_reg + 1'b1;
                    state_next   = ST_RES;
                end
            end
            ST_RES: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    if (ovf_reg) begin
                        m_tdata_next = '0;
                    end else begin
                        m_tdata_next = {dw_shifted[DWELL_W-1:0], rpm_shifted[RPM_W-1:0]};
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            widx_reg     <= '0;
            valid_reg    <= '0;
            sum_rpm_reg  <= '0;
            sum_dw_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            widx_reg     <= widx_next;
            valid_reg    <= valid_next;
            sum_rpm_reg  <= sum_rpm_next;
            sum_dw_reg   <= sum_dw_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ovf_reg     <= ovf_next;
        m_tdata_reg <= m_tdata_next;
    end

    // Ring storage with registered read.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            rpm_mem[widx_reg]   <= rpm_sample;
            dwell_mem[widx_reg] <= dw_sample;
        end
        rd_rpm_reg <= rpm_mem[widx_reg];
        rd_dw_reg  <= dwell_mem[widx_reg];
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

FILE: sv/tach_rpm_dwell_averager_core.sv
// Tachometer core: turns captured ignition pulse durations into averaged
// rpm and dwell readings.
//
// Input stream (s_*): one beat per pulse with high and low times in tdata
// and kind plus the timer-overflow flag in tuser. A clear beat empties both
// history rings. Output stream (m_*): exactly one beat per input beat with
// rpm and dwell; both read zero while the overflow flag of that beat is set.
// Configuration (APB, 32-bit data): rpm_dividend 0x0, dwell_multiplier 0x4,
// dwell_offset 0x8; users write only while the core is idle (unenforced).
//
// The front register and queue feed the back part, which divides a capture
// beat or empties the rings for a clear one and registers the result. The
// back part takes one item at a time, captures paced by the two 32-step
// serial dividers. A two-entry queue lets the front take further beats while
// a result waits. When the receiver stalls, the result holds in the output
// register and the input stalls once the front register and queue are full.
// Reset clears the rings (through valid bits), the sums, write position and
// the configuration registers; the core takes beats right after reset.
`timescale 1ns / 1ps
`default_nettype none

module tach_rpm_dwell_averager_core #(
    parameter int AVG_DEPTH = tach_pkg::DEF_AVG_DEPTH,
    parameter int AVG_SHIFT = tach_pkg::DEF_AVG_SHIFT
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // s_tdata: high_time [15:0], low_time [31:16]
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [tach_pkg::S_DATA_W-1:0]   s_tdata,
    // s_tuser: kind [0], overflowed [1]
    input  wire logic [tach_pkg::S_USER_W-1:0]   s_tuser,
    // m_tdata: rpm [15:0], dwell [23:16]
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [tach_pkg::M_DATA_W-1:0]        m_tdata,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [tach_pkg::PADDR_W-1:0]    paddr,
    input  wire logic [tach_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [tach_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                 pready
);
    import tach_pkg::*;

    cfg_t                 cfg_reg, cfg_next;
    logic                 cfg_write;
    logic [REG_IDX_W-1:0] reg_idx;

    q_entry_t             push_data;
    logic                 push_valid;
    logic                 push_ready;
    q_entry_t             pop_data;
    logic                 pop_valid;
    logic                 pop_ready;

    // Configuration registers.
    assign pready    = 1'b1;
    assign reg_idx   = paddr[PADDR_W-1:PADDR_W-REG_IDX_W];
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_write) begin
            unique case (reg_idx)
                REG_RPM_DIVIDEND:     cfg_next.rpm_dividend     = pwdata;
                REG_DWELL_MULTIPLIER: cfg_next.dwell_multiplier = pwdata[MULT_W-1:0];
                REG_DWELL_OFFSET:     cfg_next.dwell_offset     = pwdata[TIME_W-1:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Register read-back.
    always_comb begin
        unique case (reg_idx)
            REG_RPM_DIVIDEND:     prdata = cfg_reg.rpm_dividend;
            REG_DWELL_MULTIPLIER: prdata = CFG_DATA_W'(cfg_reg.dwell_multiplier);
            REG_DWELL_OFFSET:     prdata = CFG_DATA_W'(cfg_reg.dwell_offset);
            default:              prdata = '0;
        endcase
    end

    tach_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .cfg        (cfg_reg),
        .push_data  (push_data),
        .push_valid (push_valid),
        .push_ready (push_ready)
    );

    tach_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_data  (push_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .pop_data   (pop_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready)
    );

    tach_back #(
        .AVG_DEPTH (AVG_DEPTH),
        .AVG_SHIFT (AVG_SHIFT)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_data  (pop_data),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire
